@@ src/vip_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vegetation index package
// Shared types and constants for the per-pixel vegetation index pipeline.
// ----------------------------------------------------------------------------
package vip_pkg;

	localparam int DIV_STEPS  = 31;
	localparam int SQRT_STEPS = 16;

	localparam logic [14:0] SOIL_RESET = 15'd8192;
	localparam logic [16:0] ONE_Q14    = 17'd16384;
	localparam logic [14:0] TVI_OFS    = 15'd8192;
	localparam logic [30:0] HALF_Q     = 31'h2000_0000;

	localparam int M_DVI  = 0;
	localparam int M_NDVI = 1;
	localparam int M_RVI  = 2;
	localparam int M_NRVI = 3;
	localparam int M_TVI  = 4;
	localparam int M_CTVI = 5;
	localparam int M_TTVI = 6;
	localparam int M_SAVI = 7;

	typedef struct packed {
		logic               miss;
		logic               s_nz;
		logic               red_nz;
		logic               neg;
		logic               dpos;
		logic signed [16:0] d;
	} side_t;

	typedef struct packed {
		logic [16:0] rem;
		logic [30:0] low;
	} div_lane_t;

	typedef struct packed {
		div_lane_t   qa;
		div_lane_t   sv;
		div_lane_t   rv;
		logic [16:0] s;
		logic [16:0] rd;
		side_t       side;
	} div_word_t;

	typedef struct packed {
		logic [17:0] rem;
		logic [31:0] x;
		logic [15:0] root;
	} sq_lane_t;

	typedef struct packed {
		logic [15:0] ndvi;
		logic [23:0] rvi;
		logic [15:0] savi;
		logic        cpos;
		side_t       side;
	} carry_t;

	typedef struct packed {
		sq_lane_t la;
		sq_lane_t lb;
		carry_t   cr;
	} sq_word_t;

	typedef struct packed {
		logic [16:0] dvi;
		logic [15:0] ndvi;
		logic [23:0] rvi;
		logic [15:0] nrvi;
		logic [14:0] tvi;
		logic [15:0] ctvi;
		logic [14:0] ttvi;
		logic [15:0] savi;
		logic [7:0]  mask;
	} res_t;

endpackage
`default_nettype wire

@@ src/vip_div_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Divider cell
// One restoring quotient step for each of the three divider lanes.
// ----------------------------------------------------------------------------
module vip_div_cell import vip_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      vld_in,
	input  div_word_t w_in,
	output logic      vld_q,
	output div_word_t w_q
);

	function automatic div_lane_t step(div_lane_t l, logic [16:0] den);
		logic [17:0] x;
		logic        ge;
		div_lane_t   r;
		x     = {l.rem, l.low[30]};
		ge    = (x >= {1'b0, den});
		r.rem = ge ? 17'(x - {1'b0, den}) : x[16:0];
		r.low = {l.low[29:0], ge};
		return r;
	endfunction

	div_word_t nxt;

	always_comb begin
		nxt    = w_in;
		nxt.qa = step(w_in.qa, w_in.s);
		nxt.sv = step(w_in.sv, w_in.s);
		nxt.rv = step(w_in.rv, w_in.rd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_q <= nxt;
		end
	end

endmodule
`default_nettype wire

@@ src/vip_sqrt_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Square root cell
// One restoring root digit for each of the two square root lanes.
// ----------------------------------------------------------------------------
module vip_sqrt_cell import vip_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     vld_in,
	input  sq_word_t w_in,
	output logic     vld_q,
	output sq_word_t w_q
);

	function automatic sq_lane_t step(sq_lane_t l);
		logic [19:0] t;
		logic [19:0] trial;
		logic        ge;
		sq_lane_t    r;
		t      = {l.rem, l.x[31:30]};
		trial  = {2'b00, l.root, 2'b01};
		ge     = (t >= trial);
		r.rem  = ge ? 18'(t - trial) : t[17:0];
		r.x    = {l.x[29:0], 2'b00};
		r.root = {l.root[14:0], ge};
		return r;
	endfunction

	sq_word_t nxt;

	always_comb begin
		nxt    = w_in;
		nxt.la = step(w_in.la);
		nxt.lb = step(w_in.lb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_q <= nxt;
		end
	end

endmodule
`default_nettype wire

@@ src/vegetation_index_pixel.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vegetation index pixel pipeline
// Computes DVI, NDVI, RVI, NRVI, TVI, CTVI, TTVI and SAVI for one pixel a beat.
//
//   channel  handshake           payload
//   input    in_valid/in_stall   red, nir, red_missing, nir_missing
//   output   out_valid/out_stall dvi ndvi rvi nrvi tvi ctvi ttvi savi valid_mask
//   config   cfg_we              cfg_data (soil factor, Q1.14)
//
// One pixel per clock while the output is not stalled. Stages in order: input
// register, multiplier, 31 divider cells, 16 square root cells and the output register.
// Reset empties the pipeline and loads the soil factor with 0.5.
// A stalled result waits in the output register; one more beat lands in a
// skid register, after which the whole pipeline holds and in_stall rises.
// ----------------------------------------------------------------------------
module vegetation_index_pixel import vip_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [14:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        red,
	input  logic [15:0]        nir,
	input  logic               red_missing,
	input  logic               nir_missing,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [16:0] dvi,
	output logic signed [15:0] ndvi,
	output logic [23:0]        rvi,
	output logic signed [15:0] nrvi,
	output logic [14:0]        tvi,
	output logic signed [15:0] ctvi,
	output logic [14:0]        ttvi,
	output logic signed [15:0] savi,
	output logic [7:0]         valid_mask
);

	logic        en;
	logic [14:0] soil_q;

	logic        vld_s1;
	logic [15:0] red_s1;
	logic [15:0] nir_s1;
	logic        miss_s1;

	logic signed [16:0] d_c;
	logic [16:0]        ad_c;
	logic [16:0]        s_c;
	logic [16:0]        k_c;
	side_t              side_c;

	logic        vld_s2;
	logic [31:0] prod_s2;
	logic [16:0] ad_s2;
	logic [16:0] s_s2;
	logic [15:0] red_s2;
	logic [15:0] nir_s2;
	side_t       side_s2;

	logic      dv_vld [0:DIV_STEPS];
	div_word_t dv_w   [0:DIV_STEPS];
	logic      sq_vld [0:SQRT_STEPS];
	sq_word_t  sq_w   [0:SQRT_STEPS];

	logic [30:0] qa;
	logic        rnz;
	logic [17:0] nd_sum;
	logic [16:0] q_nd;
	logic [17:0] sv_sum;
	logic [16:0] q_sv;
	logic [25:0] rv_sum;
	logic [24:0] q_rv;
	logic [30:0] v3;
	logic [30:0] va;

	logic [16:0] ma_sum;
	logic [16:0] mb_sum;
	logic [15:0] ma;
	logic [15:0] mb;
	carry_t      cr;
	res_t        fin;
	logic        fin_vld;

	logic        out_rdy;
	logic        out_vld_q;
	logic        skid_vld_q;
	res_t        out_q;
	res_t        skid_q;

	assign en       = !skid_vld_q;
	assign in_stall = skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			soil_q <= SOIL_RESET;
		end else if (cfg_we) begin
			soil_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s1  <= red;
			nir_s1  <= nir;
			miss_s1 <= red_missing | nir_missing;
		end
	end

	always_comb begin
		d_c           = signed'({1'b0, nir_s1}) - signed'({1'b0, red_s1});
		ad_c          = d_c[16] ? 17'(-d_c) : d_c;
		s_c           = {1'b0, nir_s1} + {1'b0, red_s1};
		k_c           = ONE_Q14 + {2'b00, soil_q};
		side_c.miss   = miss_s1;
		side_c.s_nz   = (s_c != '0);
		side_c.red_nz = (red_s1 != '0);
		side_c.neg    = d_c[16];
		side_c.dpos   = !d_c[16] && (d_c != '0);
		side_c.d      = d_c;
	end

	// multiply stage
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= ad_c[15:0] * k_c[15:0];
			ad_s2   <= ad_c;
			s_s2    <= s_c;
			red_s2  <= red_s1;
			nir_s2  <= nir_s1;
			side_s2 <= side_c;
		end
	end

	assign dv_vld[0]      = vld_s2;
	assign dv_w[0].qa.rem = {1'b0, ad_s2[16:1]};
	assign dv_w[0].qa.low = {ad_s2[0], 30'b0};
	assign dv_w[0].sv.rem = {15'b0, prod_s2[31:30]};
	assign dv_w[0].sv.low = {prod_s2[29:0], 1'b0};
	assign dv_w[0].rv.rem = '0;
	assign dv_w[0].rv.low = {6'b0, nir_s2, 9'b0};
	assign dv_w[0].s      = s_s2;
	assign dv_w[0].rd     = {1'b0, red_s2};
	assign dv_w[0].side   = side_s2;

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		vip_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_in (dv_vld[i]),
			.w_in   (dv_w[i]),
			.vld_q  (dv_vld[i+1]),
			.w_q    (dv_w[i+1])
		);
	end

	// round quotients, form square root operands
	always_comb begin
		qa     = dv_w[DIV_STEPS].qa.low;
		rnz    = (dv_w[DIV_STEPS].qa.rem != '0);
		nd_sum = {1'b0, qa[30:14]} + 18'd1;
		q_nd   = nd_sum[17:1];
		sv_sum = {1'b0, dv_w[DIV_STEPS].sv.low[16:0]} + 18'd1;
		q_sv   = sv_sum[17:1];
		rv_sum = {1'b0, dv_w[DIV_STEPS].rv.low[24:0]} + 26'd1;
		q_rv   = rv_sum[25:1];

		cr.side = dv_w[DIV_STEPS].side;
		cr.cpos = !cr.side.neg || (qa < HALF_Q);
		if (cr.side.neg) begin
			cr.ndvi = 16'(17'(-q_nd));
		end else begin
			cr.ndvi = (q_nd > 17'd32767) ? 16'h7FFF : q_nd[15:0];
		end
		if (cr.side.neg) begin
			cr.savi = (q_sv > 17'd32768) ? 16'h8000 : 16'(17'(-q_sv));
		end else begin
			cr.savi = (q_sv > 17'd32767) ? 16'h7FFF : q_sv[15:0];
		end
		cr.rvi = q_rv[24] ? 24'hFF_FFFF : q_rv[23:0];

		if ((qa > HALF_Q) || ((qa == HALF_Q) && rnz)) begin
			v3 = qa - HALF_Q;
		end else begin
			v3 = HALF_Q - qa - {30'b0, rnz};
		end
		va = cr.side.neg ? v3 : qa;
	end

	assign sq_vld[0]       = dv_vld[DIV_STEPS];
	assign sq_w[0].la.rem  = '0;
	assign sq_w[0].la.x    = {1'b0, va};
	assign sq_w[0].la.root = '0;
	assign sq_w[0].lb.rem  = '0;
	assign sq_w[0].lb.x    = {1'b0, qa + HALF_Q};
	assign sq_w[0].lb.root = '0;
	assign sq_w[0].cr      = cr;

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		vip_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_in (sq_vld[j]),
			.w_in   (sq_w[j]),
			.vld_q  (sq_vld[j+1]),
			.w_q    (sq_w[j+1])
		);
	end

	// final rounding and masking
	always_comb begin
		carry_t c;
		logic   ok;
		logic   nz;
		c      = sq_w[SQRT_STEPS].cr;
		ma_sum = {1'b0, sq_w[SQRT_STEPS].la.root} + 17'd1;
		mb_sum = {1'b0, sq_w[SQRT_STEPS].lb.root} + 17'd1;
		ma     = ma_sum[16:1];
		mb     = mb_sum[16:1];
		ok     = !c.side.miss;
		nz     = ok && c.side.s_nz;

		fin.mask         = '0;
		fin.mask[M_DVI]  = ok;
		fin.mask[M_NDVI] = nz;
		fin.mask[M_RVI]  = ok && c.side.red_nz;
		fin.mask[M_NRVI] = nz && c.side.red_nz;
		fin.mask[M_TVI]  = nz && c.side.dpos;
		fin.mask[M_CTVI] = nz;
		fin.mask[M_TTVI] = nz;
		fin.mask[M_SAVI] = nz;

		fin.dvi  = fin.mask[M_DVI]  ? c.side.d : '0;
		fin.ndvi = fin.mask[M_NDVI] ? c.ndvi : '0;
		fin.rvi  = fin.mask[M_RVI]  ? c.rvi : '0;
		fin.nrvi = fin.mask[M_NRVI] ? c.ndvi : '0;
		fin.tvi  = fin.mask[M_TVI]  ? (ma[14:0] + TVI_OFS) : '0;
		if (!fin.mask[M_CTVI]) begin
			fin.ctvi = '0;
		end else if (!c.side.neg) begin
			fin.ctvi = mb;
		end else begin
			fin.ctvi = c.cpos ? ma : 16'(-ma);
		end
		fin.ttvi = fin.mask[M_TTVI] ? mb[14:0] : '0;
		fin.savi = fin.mask[M_SAVI] ? c.savi : '0;
	end

	assign fin_vld = sq_vld[SQRT_STEPS] && en;
	assign out_rdy = !out_vld_q || !out_stall;

	// output register and skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_rdy) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= fin_vld;
			end
		end else if (fin_vld) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy) begin
			out_q <= skid_vld_q ? skid_q : fin;
		end else if (fin_vld) begin
			skid_q <= fin;
		end
	end

	assign out_valid  = out_vld_q;
	assign dvi        = signed'(out_q.dvi);
	assign ndvi       = signed'(out_q.ndvi);
	assign rvi        = out_q.rvi;
	assign nrvi       = signed'(out_q.nrvi);
	assign tvi        = out_q.tvi;
	assign ctvi       = signed'(out_q.ctvi);
	assign ttvi       = out_q.ttvi;
	assign savi       = signed'(out_q.savi);
	assign valid_mask = out_q.mask;

endmodule
`default_nettype wire

@@ verif/vip_index_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vegetation index result checker
// Watches the pixel and result channels and the soil factor port. For each
// accepted pixel it works out the eight indices and the valid mask, queues
// them, and compares every accepted result beat with the oldest entry.
// ----------------------------------------------------------------------------
module vip_index_checker import vip_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [14:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [15:0]        red,
	input  logic [15:0]        nir,
	input  logic               red_missing,
	input  logic               nir_missing,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [16:0] dvi,
	input  logic signed [15:0] ndvi,
	input  logic [23:0]        rvi,
	input  logic signed [15:0] nrvi,
	input  logic [14:0]        tvi,
	input  logic signed [15:0] ctvi,
	input  logic [14:0]        ttvi,
	input  logic signed [15:0] savi,
	input  logic [7:0]         valid_mask,
	output int                 errors,
	output int                 pending
);

	res_t        index_q[$];
	logic [14:0] soil;

	function automatic longint rdiv(input longint num, input longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (mag * 2 + den) / (2 * den);
		return (num < 0) ? -q : q;
	endfunction

	function automatic longint sat(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic longint sqrt_ratio(input longint num, input longint den);
		longint lo;
		longint hi;
		longint mid;
		longint t;
		lo = 0;
		hi = 32767;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			t = 2 * mid - 1;
			if (t * t * den <= num * 4)
				lo = mid;
			else
				hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic res_t index_predict(input logic [15:0] r, input logic [15:0] n,
	                                       input logic rm, input logic nm,
	                                       input logic [14:0] sf);
		res_t   e;
		longint rd;
		longint nr;
		longint d;
		longint s;
		longint nd;
		longint ad;
		longint c;
		longint ac;
		longint v;
		e = '0;
		rd = r;
		nr = n;
		if (!rm && !nm) begin
			d = nr - rd;
			s = nr + rd;
			v = sat(d, -65535, 65535);
			e.dvi = v[16:0];
			e.mask[M_DVI] = 1'b1;
			if (s != 0) begin
				nd = sat(rdiv(d * 32768, s), -32768, 32767);
				ad = (d < 0) ? -d : d;
				c = 2 * d + s;
				ac = (c < 0) ? -c : c;
				e.ndvi = nd[15:0];
				e.mask[M_NDVI] = 1'b1;
				if (d > 0) begin
					v = sqrt_ratio(d << 28, s) + 8192;
					e.tvi = v[14:0];
					e.mask[M_TVI] = 1'b1;
				end
				v = sqrt_ratio(ac << 27, s);
				if (c <= 0)
					v = -v;
				e.ctvi = v[15:0];
				e.mask[M_CTVI] = 1'b1;
				v = sqrt_ratio((2 * ad + s) << 27, s);
				e.ttvi = v[14:0];
				e.mask[M_TTVI] = 1'b1;
				v = sat(rdiv(d * (16384 + longint'(sf)), s), -32768, 32767);
				e.savi = v[15:0];
				e.mask[M_SAVI] = 1'b1;
				if (rd != 0) begin
					e.nrvi = nd[15:0];
					e.mask[M_NRVI] = 1'b1;
				end
			end
			if (rd != 0) begin
				v = sat(rdiv(nr * 256, rd), 0, 16777215);
				e.rvi = v[23:0];
				e.mask[M_RVI] = 1'b1;
			end
		end
		return e;
	endfunction

	initial begin
		errors = 0;
		pending = 0;
		soil = SOIL_RESET;
	end

	always @(posedge clk) begin
		res_t got;
		res_t exp_res;
		if (arst_n) begin
			if (cfg_we)
				soil <= cfg_data;
			if (in_valid && !in_stall)
				index_q.push_back(index_predict(red, nir, red_missing, nir_missing, soil));
			if (out_valid && !out_stall) begin
				got = '{dvi, ndvi, rvi, nrvi, tvi, ctvi, ttvi, savi, valid_mask};
				if (index_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: result beat with no pixel outstanding", $realtime);
				end else begin
					exp_res = index_q.pop_front();
					if (got !== exp_res) begin
						errors++;
						if (errors <= 10) begin
							$display("%0t: mismatch exp dvi %0d ndvi %0d rvi %0d nrvi %0d",
							         $realtime, $signed(exp_res.dvi), $signed(exp_res.ndvi),
							         exp_res.rvi, $signed(exp_res.nrvi));
							$display("    exp tvi %0d ctvi %0d ttvi %0d savi %0d mask %h",
							         exp_res.tvi, $signed(exp_res.ctvi), exp_res.ttvi,
							         $signed(exp_res.savi), exp_res.mask);
							$display("    got dvi %0d ndvi %0d rvi %0d nrvi %0d",
							         dvi, ndvi, rvi, nrvi);
							$display("    got tvi %0d ctvi %0d ttvi %0d savi %0d mask %h",
							         tvi, ctvi, ttvi, savi, valid_mask);
						end
					end
				end
			end
			pending = index_q.size();
		end
	end

endmodule

@@ verif/tb_vegetation_index_pixel.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vegetation index pixel testbench
// Drives corner and random pixels through the pipeline under several soil
// factor settings, with random gaps and stalls on both channels and one long
// result hold-off; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_vegetation_index_pixel;
	import vip_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [14:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [15:0]        red;
	logic [15:0]        nir;
	logic               red_missing;
	logic               nir_missing;
	logic               out_valid;
	logic               out_stall;
	logic signed [16:0] dvi;
	logic signed [15:0] ndvi;
	logic [23:0]        rvi;
	logic signed [15:0] nrvi;
	logic [14:0]        tvi;
	logic signed [15:0] ctvi;
	logic [14:0]        ttvi;
	logic signed [15:0] savi;
	logic [7:0]         valid_mask;
	int                 errors;
	int                 pending;
	logic               busy_free;
	logic               hold_req;
	int                 hold_cnt;

	vegetation_index_pixel i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .red(red), .nir(nir),
		.red_missing(red_missing), .nir_missing(nir_missing),
		.out_valid(out_valid), .out_stall(out_stall), .dvi(dvi), .ndvi(ndvi),
		.rvi(rvi), .nrvi(nrvi), .tvi(tvi), .ctvi(ctvi), .ttvi(ttvi), .savi(savi),
		.valid_mask(valid_mask)
	);

	vip_index_checker i_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .red(red), .nir(nir),
		.red_missing(red_missing), .nir_missing(nir_missing),
		.out_valid(out_valid), .out_stall(out_stall), .dvi(dvi), .ndvi(ndvi),
		.rvi(rvi), .nrvi(nrvi), .tvi(tvi), .ctvi(ctvi), .ttvi(ttvi), .savi(savi),
		.valid_mask(valid_mask), .errors(errors), .pending(pending)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		#2_000_000;
		$display("FAIL vegetation_index_pixel");
		$finish;
	end

	// receiver: random stalls, or a long hold-off on request
	initial begin
		out_stall = 1'b0;
		hold_cnt = 0;
		forever begin
			@(negedge clk);
			if (hold_req && hold_cnt == 0)
				hold_cnt = 400;
			if (hold_cnt > 0) begin
				out_stall <= 1'b1;
				hold_cnt--;
				if (hold_cnt == 0)
					hold_req = 1'b0;
			end else if (busy_free)
				out_stall <= 1'b0;
			else
				out_stall <= ($urandom_range(99) < 28);
		end
	end

	task automatic send_pixel(input logic [15:0] r, input logic [15:0] n,
	                          input logic rm, input logic nm);
		@(negedge clk);
		while (!busy_free && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		red <= r;
		nir <= n;
		red_missing <= rm;
		nir_missing <= nm;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_soil(input logic [14:0] sf);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= sf;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(9))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'hFFFF;
			3: return 16'($urandom_range(255));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_pixels(input int count);
		logic [15:0] r;
		logic [15:0] n;
		for (int k = 0; k < count; k++) begin
			r = pick_sample();
			n = ($urandom_range(7) == 0) ? r : pick_sample();
			if ($urandom_range(5) == 0)
				r = n / 3;
			send_pixel(r, n, $urandom_range(9) == 0, $urandom_range(9) == 0);
		end
	endtask

	initial begin
		logic [14:0] soil_set[5];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		red = '0;
		nir = '0;
		red_missing = 1'b0;
		nir_missing = 1'b0;
		busy_free = 1'b0;
		hold_req = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// corners under the reset soil factor
		send_pixel(16'd0, 16'd0, 1'b0, 1'b0);
		send_pixel(16'd0, 16'hFFFF, 1'b0, 1'b0);
		send_pixel(16'hFFFF, 16'd0, 1'b0, 1'b0);
		send_pixel(16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
		send_pixel(16'd1, 16'd0, 1'b0, 1'b0);
		send_pixel(16'd0, 16'd1, 1'b0, 1'b0);
		send_pixel(16'd1, 16'hFFFF, 1'b0, 1'b0);
		send_pixel(16'd100, 16'd100, 1'b0, 1'b0);
		send_pixel(16'd300, 16'd100, 1'b0, 1'b0);
		send_pixel(16'd301, 16'd100, 1'b0, 1'b0);
		send_pixel(16'd299, 16'd100, 1'b0, 1'b0);
		send_pixel(16'h5555, 16'hAAAA, 1'b0, 1'b0);
		send_pixel(16'hAAAA, 16'h5555, 1'b0, 1'b0);
		send_pixel(16'd1000, 16'd2000, 1'b1, 1'b0);
		send_pixel(16'd1000, 16'd2000, 1'b0, 1'b1);
		send_pixel(16'd1000, 16'd2000, 1'b1, 1'b1);
		send_pixel(16'd3, 16'd7, 1'b0, 1'b0);

		soil_set = '{SOIL_RESET, 15'd0, 15'd16384, 15'd32767, 15'($urandom)};
		for (int p = 0; p < 5; p++) begin
			write_soil(soil_set[p]);
			if (p == 1) begin
				hold_req = 1'b1;
				busy_free = 1'b1;
				random_pixels(90);
				busy_free = 1'b0;
			end
			random_pixels(118);
		end
		send_pixel(16'd200, 16'd1000, 1'b0, 1'b0);

		drain();
		if (errors == 0)
			$display("PASS vegetation_index_pixel");
		else
			$display("FAIL vegetation_index_pixel");
		$finish;
	end

endmodule

@@ filelist.f @@
src/vip_pkg.sv
src/vip_div_cell.sv
src/vip_sqrt_cell.sv
src/vegetation_index_pixel.sv
verif/vip_index_checker.sv
verif/tb_vegetation_index_pixel.sv
